@@ sv/ppr_pkg.sv @@
// Package for the polar pose regulator: angle constants, arctangent table,
// register index codes and a shared angle wrap function. No dependencies.
package ppr_pkg;

    typedef logic signed [15:0] t_angle;

    localparam int ANG_W = 16;
    localparam int SQ_W = 34;
    localparam int ROOT_W = SQ_W / 2;
    localparam int Z_W = 34;
    localparam int TAB_LEN = 24;

    localparam logic signed [17:0] PI_Q13 = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // atan(2^-i) in Q2.30
    localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef enum logic [2:0] {
        REG_GOAL_X        = 3'd0,
        REG_GOAL_Y        = 3'd1,
        REG_GOAL_HEADING  = 3'd2,
        REG_GAIN_DISTANCE = 3'd3,
        REG_GAIN_ALPHA    = 3'd4,
        REG_GAIN_BETA     = 3'd5,
        REG_DIST_TOL      = 3'd6,
        REG_HEAD_TOL      = 3'd7
    } t_cfg_idx;

    // Map an angle within +-3pi into [-pi, pi)
    function automatic t_angle ppr_wrap(input logic signed [17:0] a);
        logic signed [17:0] d;
        d = a;
        if (a >= PI_Q13) begin
            d = a - TWO_PI_Q13;
        end else if (a < -PI_Q13) begin
            d = a + TWO_PI_Q13;
        end
        return ANG_W'(d);
    endfunction

endpackage

@@ sv/polar_pose_regulator.sv @@
// Polar pose regulator top level: configuration registers, pose pipeline,
// direction state and output register. Depends on ppr_pkg, ppr_delay,
// ppr_isqrt and ppr_cordic.
//
// Takes one pose word per clock while not stalled and returns one command
// word per pose, in order. The path runs through two CORDIC arctangent
// pipelines in series (goal bearing, then the turn-rate arctangent), each
// CORDIC_STEPS+3 stages deep, plus multiply and output stages. The whole
// pipeline advances together; it holds when the output word is stalled.
// Configuration writes are always ready and must be made while no pose is
// in flight.
module polar_pose_regulator #(
    parameter int CORDIC_STEPS = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_yaw,
    input  logic               i_new_move,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_linear_velocity,
    output logic signed [14:0] o_angular_velocity,
    output logic               o_arrived,
    output logic               o_reversing
);
    import ppr_pkg::*;

    localparam int LC = CORDIC_STEPS + 3;
    localparam int NS = 2 * LC + 4;
    localparam int ST_RHO = 3 + ROOT_W;

    // configuration
    logic signed [15:0] r_goal_x, r_goal_y, r_goal_heading, r_gain_beta;
    logic [14:0] r_gain_distance, r_gain_alpha, r_dist_tol, r_head_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_goal_heading <= '0;
            r_gain_distance <= 15'd819;
            r_gain_alpha <= 15'd4096;
            r_gain_beta <= -16'sd2048;
            r_dist_tol <= 15'd205;
            r_head_tol <= 15'd410;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_GOAL_X:        r_goal_x <= i_cfg_data;
                REG_GOAL_Y:        r_goal_y <= i_cfg_data;
                REG_GOAL_HEADING:  r_goal_heading <= i_cfg_data;
                REG_GAIN_DISTANCE: r_gain_distance <= i_cfg_data[14:0];
                REG_GAIN_ALPHA:    r_gain_alpha <= i_cfg_data[14:0];
                REG_GAIN_BETA:     r_gain_beta <= i_cfg_data;
                REG_DIST_TOL:      r_dist_tol <= i_cfg_data[14:0];
                REG_HEAD_TOL:      r_head_tol <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic            w_en;
    logic [NS:1]     r_vld;
    logic            r_out_valid;

    assign w_en = !r_out_valid || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-1:1], i_valid};
            r_out_valid <= r_vld[NS];
        end
    end

    // stage 1: offsets and heading error
    logic signed [16:0] r_dx, r_dy;
    logic signed [15:0] r_yaw1;
    logic               r_new1, r_hok1;
    t_angle             w_herr;
    logic [15:0]        w_herr_abs;

    always_comb begin
        w_herr = ppr_wrap(18'(r_goal_heading) - 18'(i_yaw));
        w_herr_abs = w_herr[15] ? 16'(-w_herr) : 16'(w_herr);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= 17'(i_pos_x) - 17'(r_goal_x);
            r_dy <= 17'(i_pos_y) - 17'(r_goal_y);
            r_yaw1 <= i_yaw;
            r_new1 <= i_new_move;
            r_hok1 <= w_herr_abs <= {1'b0, r_head_tol};
        end
    end

    // stages 2-3: squared distance and arrival test
    logic [SQ_W-1:0] r_dx2, r_dy2, w_sq, r_sq;
    logic [29:0]     r_tol2;
    logic            r_hok2, r_arr3;

    assign w_sq = r_dx2 + r_dy2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx2 <= SQ_W'(SQ_W'(r_dx) * SQ_W'(r_dx));
            r_dy2 <= SQ_W'(SQ_W'(r_dy) * SQ_W'(r_dy));
            r_tol2 <= 30'(r_dist_tol) * 30'(r_dist_tol);
            r_hok2 <= r_hok1;
            r_sq <= w_sq;
            r_arr3 <= (w_sq <= SQ_W'(r_tol2)) && r_hok2;
        end
    end

    logic [ROOT_W-1:0] w_rho;

    ppr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (r_sq),
        .o_root (w_rho)
    );

    // bearing to goal, forward and backward
    t_angle w_fwd, w_bwd;

    ppr_cordic #(.IN_W(17), .VW(VALUE_WIDTH), .STEPS(CORDIC_STEPS)) u_cordic_fwd (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (-r_dy),
        .i_x     (-r_dx),
        .o_angle (w_fwd)
    );

    ppr_cordic #(.IN_W(17), .VW(VALUE_WIDTH), .STEPS(CORDIC_STEPS)) u_cordic_bwd (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r_dy),
        .i_x     (r_dx),
        .o_angle (w_bwd)
    );

    logic [16:0] w_pose_d;
    ppr_delay #(.W(17), .DEPTH(LC)) u_dly_pose (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_new1, r_yaw1}),
        .o_q   (w_pose_d)
    );

    // direction decision and polar errors
    logic               r_drive_backward, w_dir, w_dir_new, w_start;
    t_angle             w_a0, w_bearing, w_alpha_w, w_bsum;
    logic signed [14:0] w_alpha, r_alpha;
    logic signed [15:0] r_bsum;
    logic               r_dir_d, r_dir_e, r_dir_f;

    always_comb begin
        w_start = r_vld[LC+1] && w_pose_d[16];
        w_a0 = ppr_wrap(18'(w_fwd) - 18'($signed(w_pose_d[15:0])));
        w_dir_new = (18'(w_a0) > HALF_PI_Q13) || (18'(w_a0) < -HALF_PI_Q13);
        w_dir = w_start ? w_dir_new : r_drive_backward;
        w_bearing = w_dir ? w_bwd : w_fwd;
        w_alpha_w = ppr_wrap(18'(w_bearing) - 18'($signed(w_pose_d[15:0])));
        if (18'(w_alpha_w) > HALF_PI_Q13) begin
            w_alpha = 15'(HALF_PI_Q13);
        end else if (18'(w_alpha_w) < -HALF_PI_Q13) begin
            w_alpha = 15'(-HALF_PI_Q13);
        end else begin
            w_alpha = 15'(w_alpha_w);
        end
        w_bsum = ppr_wrap(18'(r_goal_heading) - 18'(w_bearing));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_backward <= 1'b0;
        end else if (w_en && w_start) begin
            r_drive_backward <= w_dir_new;
        end
    end

    // gain products and sum
    logic signed [30:0] r_pa;
    logic signed [31:0] r_pb;
    logic signed [32:0] w_s, r_s;

    assign w_s = 33'(r_pa) + 33'(r_pb);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_alpha <= w_alpha;
            r_bsum <= w_bsum;
            r_dir_d <= w_dir;
            r_pa <= 31'($signed({1'b0, r_gain_alpha})) * 31'(r_alpha);
            r_pb <= 32'(r_gain_beta) * 32'(r_bsum);
            r_dir_e <= r_dir_d;
            r_s <= r_dir_e ? -w_s : w_s;
            r_dir_f <= r_dir_e;
        end
    end

    t_angle w_ang;

    ppr_cordic #(.IN_W(33), .VW(VALUE_WIDTH), .STEPS(CORDIC_STEPS)) u_cordic_turn (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r_s),
        .i_x     (33'sd33554432),
        .o_angle (w_ang)
    );

    // sidebands up to the output stage
    logic              w_dir_out, w_arr_out;
    logic [ROOT_W-1:0] w_rho_d;

    ppr_delay #(.W(1), .DEPTH(LC)) u_dly_dir (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_dir_f),
        .o_q   (w_dir_out)
    );

    ppr_delay #(.W(1), .DEPTH(NS - 3)) u_dly_arr (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_arr3),
        .o_q   (w_arr_out)
    );

    ppr_delay #(.W(ROOT_W), .DEPTH(NS - 1 - ST_RHO)) u_dly_rho (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_rho),
        .o_q   (w_rho_d)
    );

    logic [31:0] r_lprod;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lprod <= 32'(r_gain_distance) * 32'(w_rho_d);
        end
    end

    // output stage: rounding, sign, saturation, arrival gating
    logic [32:0]        w_lsum;
    logic signed [21:0] w_lin_m, w_lin_s;
    logic signed [15:0] w_lin;
    logic signed [14:0] w_ang_c;

    always_comb begin
        w_lsum = 33'(r_lprod) + 33'd2048;
        w_lin_m = $signed({1'b0, w_lsum[32:12]});
        w_lin_s = w_dir_out ? -w_lin_m : w_lin_m;
        if (w_lin_s > 22'sd32767) begin
            w_lin = 16'sd32767;
        end else if (w_lin_s < -22'sd32768) begin
            w_lin = -16'sd32768;
        end else begin
            w_lin = 16'(w_lin_s);
        end
        if (18'(w_ang) > HALF_PI_Q13) begin
            w_ang_c = 15'(HALF_PI_Q13);
        end else if (18'(w_ang) < -HALF_PI_Q13) begin
            w_ang_c = 15'(-HALF_PI_Q13);
        end else begin
            w_ang_c = 15'(w_ang);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_linear_velocity <= w_arr_out ? '0 : w_lin;
            o_angular_velocity <= w_arr_out ? '0 : w_ang_c;
            o_arrived <= w_arr_out;
            o_reversing <= w_dir_out;
        end
    end

`ifndef ASSERT_OFF
    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_arrived |-> o_linear_velocity == 0 && o_angular_velocity == 0)
        else $error("arrived word carries nonzero velocity");

    a_turn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angular_velocity <= 15'sd12868 && o_angular_velocity >= -15'sd12868)
        else $error("turn rate outside +-pi/2");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vld[NS]))
        else $error("output word without a pipeline word");
`endif
endmodule

@@ sv/ppr_delay.sv @@
// Enabled shift line that carries sideband data alongside the pipeline.
// Depends on nothing.
module ppr_delay #(
    parameter int W = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];
endmodule

@@ sv/ppr_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on ppr_pkg.
module ppr_isqrt (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ppr_pkg::SQ_W-1:0]  i_v,
    output logic [ppr_pkg::ROOT_W-1:0] o_root
);
    import ppr_pkg::*;

    logic [SQ_W-1:0] r_v [1:ROOT_W];
    logic [SQ_W-1:0] r_r [1:ROOT_W];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++) begin : g_step
            localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (SQ_W - 2 - 2*g);
            logic [SQ_W-1:0] w_v, w_r, n_v, n_r;
            logic [SQ_W:0]   w_sum;
            if (g == 0) begin : g_first
                assign w_v = i_v;
                assign w_r = '0;
            end else begin : g_next
                assign w_v = r_v[g];
                assign w_r = r_r[g];
            end
            always_comb begin
                w_sum = {1'b0, w_r} + BIT;
                if ({1'b0, w_v} >= w_sum) begin
                    n_v = SQ_W'({1'b0, w_v} - w_sum);
                    n_r = SQ_W'({1'b0, w_r >> 1} + BIT);
                end else begin
                    n_v = w_v;
                    n_r = w_r >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[g+1] <= n_v;
                    r_r[g+1] <= n_r;
                end
            end
        end
    endgenerate

    assign o_root = r_r[ROOT_W][ROOT_W-1:0];
endmodule

@@ sv/ppr_cordic.sv @@
// Pipelined atan2 by CORDIC vectoring: normalize, quadrant fold, STEPS
// rotation stages, rounding. Depends on ppr_pkg.
module ppr_cordic #(
    parameter int IN_W = 17,
    parameter int VW = 16,
    parameter int STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [IN_W-1:0] i_y,
    input  logic signed [IN_W-1:0] i_x,
    output ppr_pkg::t_angle        o_angle
);
    import ppr_pkg::*;

    localparam int PW = $clog2(IN_W);
    localparam int TGT = VW - 3;
    localparam int XW = IN_W + VW;
    localparam int CW = VW + 2;

    // normalize: find msb of the larger magnitude
    logic [IN_W-1:0] w_ax, w_ay, w_m;
    logic [PW-1:0]   w_p;
    logic signed [IN_W-1:0] r_ax_x, r_ax_y;
    logic [PW-1:0]   r_p;
    logic            r_zero_a;

    always_comb begin
        w_ax = i_x[IN_W-1] ? IN_W'(-i_x) : IN_W'(i_x);
        w_ay = i_y[IN_W-1] ? IN_W'(-i_y) : IN_W'(i_y);
        w_m = (w_ax > w_ay) ? w_ax : w_ay;
        w_p = '0;
        for (int k = 0; k < IN_W; k++) begin
            if (w_m[k]) begin
                w_p = PW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax_x <= i_x;
            r_ax_y <= i_y;
            r_p <= w_p;
            r_zero_a <= (w_m == '0);
        end
    end

    // scale and fold into the right half plane
    logic signed [XW-1:0] w_xw, w_yw;
    logic signed [CW-1:0] w_xs, w_ys, n_x0, n_y0;
    logic signed [Z_W-1:0] n_z0;

    always_comb begin
        w_xw = XW'(r_ax_x);
        w_yw = XW'(r_ax_y);
        if (int'(r_p) > TGT) begin
            w_xs = CW'(w_xw >>> (int'(r_p) - TGT));
            w_ys = CW'(w_yw >>> (int'(r_p) - TGT));
        end else begin
            w_xs = CW'(w_xw <<< (TGT - int'(r_p)));
            w_ys = CW'(w_yw <<< (TGT - int'(r_p)));
        end
        n_x0 = w_xs;
        n_y0 = w_ys;
        n_z0 = '0;
        if (w_xs < 0) begin
            if (w_ys >= 0) begin
                n_x0 = w_ys;
                n_y0 = -w_xs;
                n_z0 = HALF_PI_Q30;
            end else begin
                n_x0 = -w_ys;
                n_y0 = w_xs;
                n_z0 = -HALF_PI_Q30;
            end
        end
    end

    logic signed [CW-1:0]  r_x [0:STEPS];
    logic signed [CW-1:0]  r_y [0:STEPS];
    logic signed [Z_W-1:0] r_z [0:STEPS];
    logic                  r_zero [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
            r_zero[0] <= r_zero_a;
        end
    end

    genvar g;
    generate
        for (g = 0; g < STEPS; g++) begin : g_rot
            localparam logic signed [Z_W-1:0] ANG = Z_W'({2'b00, ATAN_TAB[g]});
            logic signed [CW-1:0] w_xsh, w_ysh;
            assign w_xsh = r_x[g] >>> g;
            assign w_ysh = r_y[g] >>> g;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_y[g] > 0) begin
                        r_x[g+1] <= r_x[g] + w_ysh;
                        r_y[g+1] <= r_y[g] - w_xsh;
                        r_z[g+1] <= r_z[g] + ANG;
                    end else begin
                        r_x[g+1] <= r_x[g] - w_ysh;
                        r_y[g+1] <= r_y[g] + w_xsh;
                        r_z[g+1] <= r_z[g] - ANG;
                    end
                    r_zero[g+1] <= r_zero[g];
                end
            end
        end
    endgenerate

    // Q2.30 to Q3.13, ties up
    logic signed [Z_W-1:0] w_zr;
    assign w_zr = r_z[STEPS] + Z_W'(65536);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= r_zero[STEPS] ? '0 : w_zr[ANG_W+16:17];
        end
    end
endmodule

@@ tb/tb_polar_pose_regulator.sv @@
// Testbench for polar_pose_regulator: random bursty pose words against a bit-exact
// predictor, with stalls on the command side. Depends on ppr_pkg and the block's RTL.
module tb_polar_pose_regulator;
    import ppr_pkg::*;

    localparam int     STEPS = 16;
    localparam int     VW = 16;
    localparam longint PI_A = 25736;
    localparam longint HALF_A = 12868;
    localparam longint HALF_Z = 1686629713;
    localparam int     DRAIN = 60;
    localparam int     LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] yaw;
        logic               nm;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] lin;
        logic signed [14:0] ang;
        logic               arr;
        logic               rev;
    } cmd_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic signed [15:0] i_yaw = '0;
    logic               i_new_move = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_linear_velocity;
    logic signed [14:0] o_angular_velocity;
    logic               o_arrived;
    logic               o_reversing;

    polar_pose_regulator DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of registers and direction bit
    logic [15:0] goal_x_r, goal_y_r, goal_hd_r, gain_b_r;
    logic [14:0] gain_d_r, gain_a_r, dist_tol_r, head_tol_r;
    logic        dir_back;

    pose_t pose_q[$];
    cmd_t  cmd_q[$];
    int    errors = 0;
    int    cycles = 0;
    logic  hold_req = 1'b0;

    function automatic longint wrap_ang(longint a);
        longint d;
        d = (a + PI_A) % (2 * PI_A);
        if (d < 0) d += 2 * PI_A;
        return d - PI_A;
    endfunction

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint cordic_atan2(longint y, longint x);
        longint lim, m, z, t, xs, ys;
        lim = longint'(1) << (VW - 2);
        z = 0;
        if (x == 0 && y == 0) return 0;
        m = abs_l(x) > abs_l(y) ? abs_l(x) : abs_l(y);
        while (m >= lim) begin
            x = x >>> 1;
            y = y >>> 1;
            m = m >> 1;
        end
        while (m != 0 && m < (lim >> 1)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_Z;
            end else begin
                x = -y; y = t; z = -HALF_Z;
            end
        end
        for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
            end
        end
        return (z + 65536) >>> 17;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // updates dir_back on a new move, as the block does
    function automatic cmd_t velocity_cmd(pose_t p);
        longint px, py, yw, gh, dx, dy, fwd, bear, alpha, bsum, herr, lin, ang, s, a0, tol;
        longint unsigned sq;
        logic arr;
        cmd_t r;
        px = longint'($signed(p.px));
        py = longint'($signed(p.py));
        yw = longint'($signed(p.yaw));
        gh = longint'($signed(goal_hd_r));
        dx = px - longint'($signed(goal_x_r));
        dy = py - longint'($signed(goal_y_r));
        fwd = cordic_atan2(-dy, -dx);
        tol = longint'(dist_tol_r);
        sq = longint'(dx * dx + dy * dy);
        lin = 0;
        ang = 0;
        if (p.nm) begin
            a0 = wrap_ang(fwd - yw);
            dir_back = (a0 > HALF_A || a0 < -HALF_A);
        end
        bear = dir_back ? cordic_atan2(dy, dx) : fwd;
        alpha = wrap_ang(bear - yw);
        if (alpha > HALF_A) alpha = HALF_A;
        if (alpha < -HALF_A) alpha = -HALF_A;
        bsum = wrap_ang(gh - bear);
        herr = wrap_ang(gh - yw);
        arr = (sq <= longint'(tol * tol)) && (abs_l(herr) <= longint'(head_tol_r));
        if (!arr) begin
            s = longint'(gain_a_r) * alpha + longint'($signed(gain_b_r)) * bsum;
            lin = (longint'(gain_d_r) * int_sqrt(sq) + 2048) >>> 12;
            if (dir_back) begin
                lin = -lin;
                s = -s;
            end
            if (lin > 32767) lin = 32767;
            if (lin < -32768) lin = -32768;
            ang = cordic_atan2(s, longint'(1) << 25);
            if (ang > HALF_A) ang = HALF_A;
            if (ang < -HALF_A) ang = -HALF_A;
        end
        r.lin = lin[15:0];
        r.ang = ang[14:0];
        r.arr = arr;
        r.rev = dir_back;
        return r;
    endfunction

    // pose driver: bursts with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                cmd_q.push_back(velocity_cmd({i_pos_x, i_pos_y, i_yaw, i_new_move}));
            end
            if (i_valid && o_stall) begin
                // hold the stalled word
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pose_q.size() > 0) begin
                pose_t p;
                p = pose_q.pop_front();
                i_pos_x <= p.px;
                i_pos_y <= p.py;
                i_yaw <= p.yaw;
                i_new_move <= p.nm;
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // command monitor and stall pattern
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int phase_ctr = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (o_valid && !i_stall && i_rst_n) begin
            if (cmd_q.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected command word at cycle %0d", cycles);
            end else begin
                cmd_t e;
                e = cmd_q.pop_front();
                if (e.lin !== o_linear_velocity || e.ang !== o_angular_velocity
                        || e.arr !== o_arrived || e.rev !== o_reversing) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: exp lin %0d ang %0d arr %b rev %b, got %0d %0d %b %b",
                                 e.lin, e.ang, e.arr, e.rev, o_linear_velocity,
                                 o_angular_velocity, o_arrived, o_reversing);
                end
            end
        end
        phase_ctr <= phase_ctr + 1;
        if (hold_req && hold_left == 0) begin
            hold_left <= 300;
            i_stall <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            if (hold_left == 1) hold_left <= -1;
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 1) == 1);
                default: i_stall <= (phase_ctr % 5 == 0);
            endcase
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_GOAL_X:        goal_x_r = d;
            REG_GOAL_Y:        goal_y_r = d;
            REG_GOAL_HEADING:  goal_hd_r = d;
            REG_GAIN_DISTANCE: gain_d_r = d[14:0];
            REG_GAIN_ALPHA:    gain_a_r = d[14:0];
            REG_GAIN_BETA:     gain_b_r = d;
            REG_DIST_TOL:      dist_tol_r = d[14:0];
            default:           head_tol_r = d[14:0];
        endcase
    endtask

    task automatic cfg_all(input logic [15:0] gx, gy, gh, gd, ga, gb, dt, ht);
        cfg_write(REG_GOAL_X, gx);
        cfg_write(REG_GOAL_Y, gy);
        cfg_write(REG_GOAL_HEADING, gh);
        cfg_write(REG_GAIN_DISTANCE, gd);
        cfg_write(REG_GAIN_ALPHA, ga);
        cfg_write(REG_GAIN_BETA, gb);
        cfg_write(REG_DIST_TOL, dt);
        cfg_write(REG_HEAD_TOL, ht);
    endtask

    task automatic drain();
        while (pose_q.size() != 0 || i_valid || cmd_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic add_pose(input int x, y, yw, input bit nm);
        pose_q.push_back({16'(x), 16'(y), 16'(yw), nm});
    endtask

    // moves of a few samples toward the goal, some landing inside tolerance, plus noise
    task automatic add_random(input int n);
        int k, reach, x, y, yw;
        k = 0;
        while (k < n) begin
            reach = $urandom_range(0, 3);
            for (int j = 0; j < $urandom_range(2, 12) && k < n; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    x = $urandom_range(0, 65535);
                    y = $urandom_range(0, 65535);
                    yw = $urandom_range(0, 65535);
                end else begin
                    int span;
                    span = (reach == 0) ? 32 : (reach == 1) ? 600 : (reach == 2) ? 8000 : 32767;
                    x = $signed(goal_x_r) + $urandom_range(0, 2 * span) - span;
                    y = $signed(goal_y_r) + $urandom_range(0, 2 * span) - span;
                    if (reach == 0)
                        yw = $signed(goal_hd_r) + $urandom_range(0, 1200) - 600;
                    else
                        yw = $urandom_range(0, 2 * 25736) - 25736;
                end
                add_pose(x, y, yw, j == 0 || $urandom_range(0, 15) == 0);
                k++;
            end
        end
    endtask

    initial begin
        goal_x_r = 16'd0;
        goal_y_r = 16'd0;
        goal_hd_r = 16'd0;
        gain_d_r = 15'd819;
        gain_a_r = 15'd4096;
        gain_b_r = 16'hF800;
        dist_tol_r = 15'd205;
        head_tol_r = 15'd410;
        dir_back = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DRAIN) @(posedge i_clk);

        // directed: forward before any move, goal behind, extremes, arrival, zero offset
        add_pose(4096, 4096, 0, 1'b0);
        add_pose(0, 0, 0, 1'b0);
        add_pose(0, 0, 0, 1'b1);
        add_pose(100, -50, 100, 1'b0);
        add_pose(-8192, 0, 0, 1'b1);
        add_pose(-8192, 0, 25736, 1'b1);
        add_pose(8192, 0, 0, 1'b1);
        add_pose(32767, 32767, -25736, 1'b1);
        add_pose(-32768, -32768, 25736, 1'b0);
        add_pose(32767, -32768, 32767, 1'b1);
        add_pose(-32768, 32767, -32768, 1'b1);
        add_pose(205, 0, 410, 1'b0);
        add_pose(206, 0, 0, 1'b0);
        add_pose(0, 205, -411, 1'b0);
        add_pose(0, -4096, 12868, 1'b1);
        add_pose(0, 4096, -12869, 1'b1);
        add_pose(-1, -1, -1, 1'b0);
        add_pose(1, 0, 25735, 1'b1);
        drain();

        cfg_all(16'h7FFF, 16'h8000, 16'd25736, 16'h7FFF, 16'h7FFF, 16'h8000,
                16'h7FFF, 16'h7FFF);
        add_random(150);
        repeat (20) @(posedge i_clk);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        drain();

        cfg_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 51472) - 25736), 16'($urandom_range(0, 4000)),
                16'($urandom_range(2000, 9000)), 16'(-$urandom_range(0, 6000)),
                16'($urandom_range(0, 2000)), 16'($urandom_range(0, 3000)));
        add_random(200);
        drain();

        cfg_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 16'h0000);
        add_random(100);
        drain();

        cfg_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        add_random(200);
        drain();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
